>>> rtl/stv_pkg.sv
`timescale 1ns / 1ps

package stv_pkg;

    localparam int NumServos = 8;
    localparam int IdxW      = 3;
    localparam int DivSteps  = 9;

    // Reciprocal of 38 scaled by 2**20, exact for products below 30841.
    localparam int RecipMul   = 27595;
    localparam int RecipShift = 20;

    typedef enum logic [1:0] {
        FUNC_TARGET = 2'd0,
        FUNC_DIRECT = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef struct packed {
        logic accept_target;
        logic accept_direct;
        logic accept_tick;
        logic mask_load;
        logic idx_inc;
        logic div_start;
        logic interp;
        logic drv1;
        logic drv2;
        logic drv3;
    } t_cmd;

    typedef struct packed {
        logic cur_active;
        logic idx_end;
        logic div_busy;
    } t_sts;

    function automatic logic [2:0] chan_map(input logic [IdxW-1:0] idx);
        logic [2:0] c;
        case (idx)
            3'd0: c = 3'd1;
            3'd1: c = 3'd0;
            3'd2: c = 3'd5;
            3'd3: c = 3'd4;
            3'd4: c = 3'd3;
            3'd5: c = 3'd2;
            3'd6: c = 3'd7;
            default: c = 3'd6;
        endcase
        return c;
    endfunction

    function automatic logic pol_neg(input logic [IdxW-1:0] idx);
        logic p;
        case (idx)
            3'd1, 3'd3, 3'd4, 3'd6: p = 1'b1;
            default: p = 1'b0;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] neutral(input logic [IdxW-1:0] idx);
        logic [7:0] n;
        case (idx)
            3'd0: n = 8'd79;
            3'd1: n = 8'd90;
            3'd2: n = 8'd77;
            default: n = 8'd94;
        endcase
        return n;
    endfunction

    function automatic logic signed [7:0] lo_lim(input logic [IdxW-1:0] idx);
        logic signed [7:0] l;
        case (idx)
            3'd1, 3'd5: l = -8'sd70;
            3'd3, 3'd7: l = -8'sd90;
            default: l = -8'sd35;
        endcase
        return l;
    endfunction

    function automatic logic signed [7:0] hi_lim(input logic [IdxW-1:0] idx);
        logic signed [7:0] h;
        case (idx)
            3'd1, 3'd5: h = 8'sd60;
            3'd3, 3'd7: h = 8'sd45;
            default: h = 8'sd100;
        endcase
        return h;
    endfunction

endpackage

>>> rtl/stv_div.sv
`timescale 1ns / 1ps

module stv_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [15:0] i_el,
    input  logic [15:0] i_len,
    output logic        o_busy,
    output logic [8:0]  o_quot
);

    logic [3:0]  r_cnt;
    logic [15:0] r_rem;
    logic [8:0]  r_quot;
    logic [16:0] t;
    logic        ge;
    logic [16:0] diff;

    // The elapsed time never exceeds the length, so the first step takes no shift.
    assign t    = (r_cnt == 4'(stv_pkg::DivSteps)) ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign ge   = t >= {1'b0, i_len};
    assign diff = t - {1'b0, i_len};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 4'(stv_pkg::DivSteps);
        end else if (r_cnt != 4'd0) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_el;
            r_quot <= '0;
        end else if (r_cnt != 4'd0) begin
            r_rem  <= ge ? diff[15:0] : t[15:0];
            r_quot <= {r_quot[7:0], ge};
        end
    end

    assign o_busy = r_cnt != 4'd0;
    assign o_quot = r_quot;

endmodule

>>> rtl/stv_dp.sv
`timescale 1ns / 1ps

module stv_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  stv_pkg::t_cmd        i_cmd,
    output stv_pkg::t_sts        o_sts,
    input  logic [2:0]           i_servo_index,
    input  logic signed [7:0]    i_angle,
    input  logic [15:0]          i_move_time,
    input  logic [31:0]          i_now_ms,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output logic [2:0]           o_pwm_channel,
    output logic [11:0]          o_on_count,
    output logic [11:0]          o_off_count,
    output logic                 o_last
);

    localparam int N = stv_pkg::NumServos;

    logic signed [7:0] r_calib   [N];
    logic signed [7:0] r_cmd_pos [N];
    logic signed [7:0] r_st_pos  [N];
    logic signed [7:0] r_end_pos [N];
    logic [31:0]       r_st_time [N];
    logic [15:0]       r_len     [N];

    logic [31:0]                 r_now;
    logic [stv_pkg::IdxW-1:0]    r_idx;
    logic [N-1:0]                r_mask;
    logic signed [7:0]           r_deg;
    logic                        r_last;
    logic signed [9:0]           r_sum;
    logic [14:0]                 r_v;
    logic [2:0]                  r_chan;
    logic [11:0]                 r_on;
    logic [11:0]                 r_off;
    logic                        r_olast;

    logic [N-1:0]      n_mask;
    logic [31:0]       el_cur;
    logic              div_busy;
    logic [8:0]        quot;
    logic signed [8:0] diff;
    logic signed [18:0] prod;
    logic [7:0]        n_pos;
    logic [N-1:0]      above;
    logic              cur_last;
    logic signed [7:0] lo;
    logic signed [7:0] hi;
    logic signed [7:0] d0;
    logic signed [9:0] s;
    logic signed [10:0] t;
    logic signed [10:0] tc;
    logic [7:0]        x;
    logic [29:0]       qprod;
    logic [9:0]        span;
    logic [11:0]       on_n;

    always_comb begin
        logic [31:0] e;
        for (int i = 0; i < N; i++) begin
            e = i_now_ms - r_st_time[i];
            n_mask[i] = (r_len[i] != 16'd0) && (e[30:0] <= {15'd0, r_len[i]});
        end
    end

    assign el_cur = r_now - r_st_time[r_idx];

    stv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_el    (el_cur[15:0]),
        .i_len   (r_len[r_idx]),
        .o_busy  (div_busy),
        .o_quot  (quot)
    );

    assign diff  = 9'(r_end_pos[r_idx]) - 9'(r_st_pos[r_idx]);
    assign prod  = diff * $signed({1'b0, quot});
    // Low byte of floor(diff*k/256) + start; the sum always fits a signed byte.
    assign n_pos = prod[15:8] + r_st_pos[r_idx];
    assign above = N'({N{1'b1}} << ({1'b0, r_idx} + 4'd1));
    assign cur_last = (r_mask & above) == '0;

    assign lo = stv_pkg::lo_lim(r_idx);
    assign hi = stv_pkg::hi_lim(r_idx);
    assign d0 = (r_deg > hi) ? hi : ((r_deg < lo) ? lo : r_deg);

    assign s  = stv_pkg::pol_neg(r_idx) ? -r_sum : r_sum;
    assign t  = 11'(s) + $signed({3'b000, stv_pkg::neutral(r_idx)});
    assign tc = (t > 11'sd185) ? 11'sd185 : ((t < -11'sd5) ? -11'sd5 : t);
    assign x  = 8'(tc + 11'sd5);

    assign qprod = 30'(r_v) * 30'(stv_pkg::RecipMul);
    assign span  = 10'(qprod[29:stv_pkg::RecipShift]) + 10'd90;
    assign on_n  = {r_idx, 9'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_calib[i]   <= '0;
                r_cmd_pos[i] <= '0;
                r_st_pos[i]  <= '0;
                r_end_pos[i] <= -8'sd1;
                r_st_time[i] <= '0;
                r_len[i]     <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_calib[i_cfg_index] <= i_cfg_data;
            end
            if (i_cmd.accept_target) begin
                r_st_time[i_servo_index] <= i_now_ms;
                r_len[i_servo_index]     <= i_move_time;
                r_st_pos[i_servo_index]  <= r_cmd_pos[i_servo_index];
                r_end_pos[i_servo_index] <= i_angle;
            end
            if (i_cmd.accept_direct) begin
                r_end_pos[i_servo_index] <= i_angle;
            end
            if (i_cmd.drv1) begin
                r_cmd_pos[r_idx] <= r_deg;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept_direct) begin
            r_idx  <= i_servo_index;
            r_deg  <= i_angle;
            r_last <= 1'b1;
        end
        if (i_cmd.accept_tick) begin
            r_now  <= i_now_ms;
            r_mask <= n_mask;
        end
        if (i_cmd.mask_load) begin
            r_idx <= '0;
        end
        if (i_cmd.idx_inc) begin
            r_idx <= r_idx + 3'd1;
        end
        if (i_cmd.interp) begin
            r_deg  <= n_pos;
            r_last <= cur_last;
        end
        if (i_cmd.drv1) begin
            r_sum <= 10'(d0) + 10'(r_calib[r_idx]);
        end
        if (i_cmd.drv2) begin
            r_v <= 15'(x) * 15'd91;
        end
        if (i_cmd.drv3) begin
            r_chan  <= stv_pkg::chan_map(r_idx);
            r_on    <= on_n;
            r_off   <= on_n + 12'(span);
            r_olast <= r_last;
        end
    end

    assign o_sts.cur_active = r_mask[r_idx];
    assign o_sts.idx_end    = r_idx == 3'(N - 1);
    assign o_sts.div_busy   = div_busy;

    assign o_pwm_channel = r_chan;
    assign o_on_count    = r_on;
    assign o_off_count   = r_off;
    assign o_last        = r_olast;

endmodule

>>> rtl/stv_ctrl.sv
`timescale 1ns / 1ps

module stv_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_func,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  stv_pkg::t_sts i_sts,
    output stv_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_MASK, S_SCAN, S_DIV, S_DRV1, S_DRV2, S_DRV3, S_OUT
    } t_state;

    t_state r_state;
    logic   r_tick;
    logic   r_out_valid;
    logic   acc;

    assign o_in_stall = r_state != S_IDLE;
    assign acc        = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    unique case (stv_pkg::t_func'(i_func))
                        stv_pkg::FUNC_TARGET: o_cmd.accept_target = 1'b1;
                        stv_pkg::FUNC_DIRECT: o_cmd.accept_direct = 1'b1;
                        stv_pkg::FUNC_TICK:   o_cmd.accept_tick   = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_MASK: o_cmd.mask_load = 1'b1;
            S_SCAN: begin
                if (i_sts.cur_active) begin
                    o_cmd.div_start = 1'b1;
                end else if (!i_sts.idx_end) begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_DIV:  o_cmd.interp = !i_sts.div_busy;
            S_DRV1: o_cmd.drv1 = 1'b1;
            S_DRV2: o_cmd.drv2 = 1'b1;
            S_DRV3: o_cmd.drv3 = 1'b1;
            S_OUT: begin
                if (!i_out_stall && r_tick && !i_sts.idx_end) begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        unique case (stv_pkg::t_func'(i_func))
                            stv_pkg::FUNC_DIRECT: begin
                                r_tick  <= 1'b0;
                                r_state <= S_DRV1;
                            end
                            stv_pkg::FUNC_TICK: begin
                                r_tick  <= 1'b1;
                                r_state <= S_MASK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_MASK: r_state <= S_SCAN;
                S_SCAN: begin
                    if (i_sts.cur_active) begin
                        r_state <= S_DIV;
                    end else if (i_sts.idx_end) begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIV: begin
                    if (!i_sts.div_busy) begin
                        r_state <= S_DRV1;
                    end
                end
                S_DRV1: r_state <= S_DRV2;
                S_DRV2: r_state <= S_DRV3;
                S_DRV3: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state <= (r_tick && !i_sts.idx_end) ? S_SCAN : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/servo_trajectory_pwm.sv
`timescale 1ns / 1ps
// Set-target words are accepted in the idle state and give no result.
// Direct-set words: the result word is valid after the DRV1, DRV2 and DRV3 steps.
// Tick words: the mask is loaded, then each servo is scanned in turn; each active servo
// goes through the 9-step divider, interpolation, 3 drive steps and output.
// One word is worked on at a time; stall on the output holds the word in progress.
// Synchronous active-low reset clears move state, calibration and handshakes; end positions reset to -1.
module servo_trajectory_pwm (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_func,
    input  logic [2:0]         i_servo_index,
    input  logic signed [7:0]  i_angle,
    input  logic [15:0]        i_move_time,
    input  logic [31:0]        i_now_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_pwm_channel,
    output logic [11:0]        o_on_count,
    output logic [11:0]        o_off_count,
    output logic               o_last,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [7:0]         i_cfg_data
);

    stv_pkg::t_cmd cmd;
    stv_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    stv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_func),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    stv_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_servo_index (i_servo_index),
        .i_angle       (i_angle),
        .i_move_time   (i_move_time),
        .i_now_ms      (i_now_ms),
        .i_cfg_we      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_pwm_channel (o_pwm_channel),
        .o_on_count    (o_on_count),
        .o_off_count   (o_off_count),
        .o_last        (o_last)
    );

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input accepted while a result word is pending");

    a_stagger: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_on_count[8:0] == 9'd0))
        else $error("on count not on a 512 boundary");

    a_pulse_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((12'(o_off_count - o_on_count) >= 12'd90) &&
                         (12'(o_off_count - o_on_count) <= 12'd545)))
        else $error("pulse width out of range");

endmodule
